// ----- hw/rtl/swrd_pkg.sv -----
// swrd_pkg: shared types, constants and helpers for the sliding window range detector
// no dependencies; imported by swrd_ram and sliding_window_range_detector_top
`default_nettype none

package swrd_pkg;

  // parameter defaults
  localparam int DEF_MAX_WINDOW     = 1024;
  localparam int DEF_SAMPLE_BITS    = 20;
  localparam int DEF_MAX_STREAM_LEN = 1048576;

  // configuration register widths and port shape
  localparam int WLEN_W     = 11;
  localparam int THR_W      = 20;
  localparam int CFG_DATA_W = 20;
  localparam int CFG_IDX_W  = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD  = 1'd1;

  // register reset values
  localparam logic [WLEN_W-1:0] WLEN_RESET = 11'd16;
  localparam logic [THR_W-1:0]  THR_RESET  = 20'd0;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FRONT_RD,
    ST_FRONT_CMP,
    ST_BACK_RD,
    ST_BACK_CMP,
    ST_PUSH,
    ST_EVAL_RD,
    ST_EVAL_DIFF,
    ST_EVAL_THR,
    ST_FINISH
  } swrd_state_t;

  // larger of two elaboration-time integers
  function automatic int max_int(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/swrd_ram.sv -----
// swrd_ram: one deque store, one write port and one read port with registered data
// depends on swrd_pkg
`default_nettype none

module swrd_ram
  import swrd_pkg::*;
#(
  parameter int AW = 10,
  parameter int DW = 31
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/sliding_window_range_detector_top.sv -----
// sliding_window_range_detector_top: monotonic deque min/max range check over a sample stream
// depends on swrd_pkg and swrd_ram
//
// Usage: samples enter on the input channel (in_valid/in_stall, sample, last_sample).
// Each sample runs through a small sequencer that updates a min deque and a max deque
// (one store each, entries are position and value) using a single shared subtractor
// for age, value, fill, range and threshold compares. Once a full window has been seen, the
// window range (max - min) is checked against threshold; a pass gives one result with the
// 1-based window start. The sample flagged last_sample closes the stream: if no
// window passed, one result with none_found set is given, then stream state clears.
// Steps per sample: for each deque, min first, a front read and compare, a back read and
// compare, then the push; each dropped entry adds one store read and one compare, and an
// empty deque skips both compares. Then come the fill check, range and threshold steps
// and finish; before the window fills the range and threshold steps are skipped, and the
// threshold step also when max sits below min. A result raises out_valid as in_stall falls.
// in_stall stays high while a sample is in work. Results sit in an output register;
// if the receiver stalls, a following result waits in the last sequencer step.
// Reset: synchronous rst clears the deques, counters and config registers (window_len 16,
// threshold 0). Store contents need no clearing. Config writes are taken any cycle.
`default_nettype none

module sliding_window_range_detector_top
  import swrd_pkg::*;
#(
  parameter int MAX_WINDOW     = DEF_MAX_WINDOW,
  parameter int SAMPLE_BITS    = DEF_SAMPLE_BITS,
  parameter int MAX_STREAM_LEN = DEF_MAX_STREAM_LEN
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  // configuration
  input  wire logic                                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]                   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]                  cfg_data,
  // input channel
  input  wire logic                                   in_valid,
  output logic                                        in_stall,
  input  wire logic [SAMPLE_BITS-1:0]                 sample,
  input  wire logic                                   last_sample,
  // output channel
  output logic                                        out_valid,
  input  wire logic                                   out_stall,
  output logic [$clog2(MAX_STREAM_LEN):0]             start_pos,
  output logic                                        none_found
);

  localparam int AW  = $clog2(MAX_WINDOW);
  localparam int PW  = AW + 1;
  localparam int SZW = AW + 1;
  localparam int CW  = $clog2(MAX_STREAM_LEN) + 1;
  localparam int WW  = max_int(WLEN_W, PW);
  localparam int SW  = max_int(CW, WW);
  localparam int UW  = max_int(max_int(SAMPLE_BITS, THR_W), max_int(WW, CW));
  localparam int DW  = PW + SAMPLE_BITS;

  // configuration registers
  logic [WLEN_W-1:0] window_len;
  logic [THR_W-1:0]  threshold;

  // sequencer and stream state
  swrd_state_t      state, state_next;
  logic             cur;
  logic [AW-1:0]    min_head, max_head;
  logic [SZW-1:0]   min_size, max_size;
  logic [PW-1:0]    pos;
  logic [CW-1:0]    count;
  logic             found;

  // per-item working registers
  logic [SAMPLE_BITS-1:0] s;
  logic                   last;
  logic [WW-1:0]          win;
  logic                   hit;
  logic [UW-1:0]          diff;

  // store ports
  logic          min_we, max_we;
  logic [AW-1:0] min_raddr, max_raddr, cur_waddr;
  logic [DW-1:0] min_rdata, max_rdata, cur_entry, wdata;

  // shared subtractor
  logic [UW-1:0] op_a, op_b;
  logic [UW:0]   sub;
  logic          borrow;

  // misc decode
  logic [AW-1:0]          cur_head;
  logic [SZW-1:0]         cur_size;
  logic [PW-1:0]          ent_pos, age;
  logic [SAMPLE_BITS-1:0] ent_val, lo_val, hi_val;
  logic [WW-1:0]          wlen_ext, win_clamp;
  logic                   emit, out_busy, finish_go;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      window_len <= WLEN_RESET;
      threshold  <= THR_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW_LEN: window_len <= cfg_data[WLEN_W-1:0];
        REG_THRESHOLD:  threshold  <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // window length clamped to 1..MAX_WINDOW
  always_comb begin
    wlen_ext = WW'(window_len);
    if (wlen_ext == '0) begin
      win_clamp = WW'(1);
    end else if (wlen_ext > WW'(MAX_WINDOW)) begin
      win_clamp = WW'(MAX_WINDOW);
    end else begin
      win_clamp = wlen_ext;
    end
  end

  // deque selection and entry decode
  assign cur_head  = cur ? max_head : min_head;
  assign cur_size  = cur ? max_size : min_size;
  assign cur_entry = cur ? max_rdata : min_rdata;
  assign ent_pos   = cur_entry[DW-1 -: PW];
  assign ent_val   = cur_entry[SAMPLE_BITS-1:0];
  assign lo_val    = min_rdata[SAMPLE_BITS-1:0];
  assign hi_val    = max_rdata[SAMPLE_BITS-1:0];
  assign age       = pos - ent_pos;

  // store addressing: back entry while scanning the back, else the front
  assign min_raddr = (state == ST_BACK_RD) ? (min_head + min_size[AW-1:0] - AW'(1)) : min_head;
  assign max_raddr = (state == ST_BACK_RD) ? (max_head + max_size[AW-1:0] - AW'(1)) : max_head;
  assign cur_waddr = cur_head + cur_size[AW-1:0];
  assign wdata     = {pos, s};
  assign min_we    = (state == ST_PUSH) && !cur;
  assign max_we    = (state == ST_PUSH) && cur;

  swrd_ram #(.AW(AW), .DW(DW)) u_min_ram (
    .clk   (clk),
    .we    (min_we),
    .waddr (cur_waddr),
    .wdata (wdata),
    .raddr (min_raddr),
    .rdata (min_rdata)
  );

  swrd_ram #(.AW(AW), .DW(DW)) u_max_ram (
    .clk   (clk),
    .we    (max_we),
    .waddr (cur_waddr),
    .wdata (wdata),
    .raddr (max_raddr),
    .rdata (max_rdata)
  );

  // shared subtractor operand select; borrow means a < b
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state)
      ST_FRONT_CMP: begin
        op_a = UW'(age);
        op_b = UW'(win);
      end
      ST_BACK_CMP: begin
        if (cur) begin
          op_a = UW'(s);
          op_b = UW'(ent_val);
        end else begin
          op_a = UW'(ent_val);
          op_b = UW'(s);
        end
      end
      ST_EVAL_RD: begin
        op_a = UW'(count);
        op_b = UW'(win);
      end
      ST_EVAL_DIFF: begin
        op_a = UW'(hi_val);
        op_b = UW'(lo_val);
      end
      ST_EVAL_THR: begin
        op_a = UW'(threshold);
        op_b = diff;
      end
      default: ;
    endcase
  end

  assign sub    = {1'b0, op_a} - {1'b0, op_b};
  assign borrow = sub[UW];

  // result decision
  assign emit      = hit || (last && !found);
  assign out_busy  = out_valid && out_stall;
  assign finish_go = !(emit && out_busy);
  assign in_stall  = rst || (state != ST_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_FRONT_RD;
      end
      ST_FRONT_RD: begin
        state_next = (cur_size == '0) ? ST_BACK_RD : ST_FRONT_CMP;
      end
      ST_FRONT_CMP: begin
        // front expired: pop and look again
        state_next = borrow ? ST_BACK_RD : ST_FRONT_RD;
      end
      ST_BACK_RD: begin
        state_next = (cur_size == '0) ? ST_PUSH : ST_BACK_CMP;
      end
      ST_BACK_CMP: begin
        // back dominated by the new sample: pop and look again
        state_next = borrow ? ST_PUSH : ST_BACK_RD;
      end
      ST_PUSH: begin
        state_next = cur ? ST_EVAL_RD : ST_FRONT_RD;
      end
      ST_EVAL_RD: begin
        state_next = borrow ? ST_FINISH : ST_EVAL_DIFF;
      end
      ST_EVAL_DIFF: begin
        state_next = borrow ? ST_FINISH : ST_EVAL_THR;
      end
      ST_EVAL_THR: begin
        state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (finish_go) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // stream control state
  always_ff @(posedge clk) begin
    if (rst) begin
      cur      <= 1'b0;
      min_head <= '0;
      max_head <= '0;
      min_size <= '0;
      max_size <= '0;
      pos      <= '0;
      count    <= '0;
      found    <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            cur <= 1'b0;
            pos <= pos + PW'(1);
            if (count < CW'(MAX_STREAM_LEN)) count <= count + CW'(1);
          end
        end
        ST_FRONT_CMP: begin
          if (!borrow) begin
            if (cur) begin
              max_head <= max_head + AW'(1);
              max_size <= max_size - SZW'(1);
            end else begin
              min_head <= min_head + AW'(1);
              min_size <= min_size - SZW'(1);
            end
          end
        end
        ST_BACK_CMP: begin
          if (!borrow) begin
            if (cur) max_size <= max_size - SZW'(1);
            else     min_size <= min_size - SZW'(1);
          end
        end
        ST_PUSH: begin
          if (cur) max_size <= max_size + SZW'(1);
          else     min_size <= min_size + SZW'(1);
          cur <= 1'b1;
        end
        ST_FINISH: begin
          if (finish_go) begin
            // stream end clears everything for the next stream
            if (last) begin
              min_head <= '0;
              max_head <= '0;
              min_size <= '0;
              max_size <= '0;
              pos      <= '0;
              count    <= '0;
              found    <= 1'b0;
            end else begin
              found <= found || hit;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // per-item working registers
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          s    <= sample;
          last <= last_sample;
          win  <= win_clamp;
          hit  <= 1'b0;
        end
      end
      ST_EVAL_DIFF: begin
        diff <= sub[UW-1:0];
        // max below min counts as zero range
        if (borrow) hit <= 1'b1;
      end
      ST_EVAL_THR: begin
        if (!borrow) hit <= 1'b1;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (state == ST_FINISH && emit && !out_busy) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && emit && !out_busy) begin
      start_pos  <= hit ? CW'(SW'(count) - SW'(win) + SW'(1)) : '0;
      none_found <= !hit;
    end
  end

  // deque occupancy never exceeds the store
  a_size_bound: assert property (@(posedge clk) disable iff (rst)
    (min_size <= SZW'(MAX_WINDOW)) && (max_size <= SZW'(MAX_WINDOW)))
    else $error("deque size beyond store depth");

  // neither deque is empty when the window is checked
  a_eval_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EVAL_RD) |-> (min_size != '0) && (max_size != '0))
    else $error("empty deque at window check");

  // a none result carries a zero start position
  a_none_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && none_found) |-> (start_pos == '0))
    else $error("none result with nonzero start position");

  // a pending result is not overwritten while the receiver stalls
  a_finish_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && emit && out_busy) |=> (state == ST_FINISH) && out_valid)
    else $error("result lost under stall");

  // an input transfer starts the sequencer
  a_accept_start: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && in_valid) |=> (state == ST_FRONT_RD) && in_stall)
    else $error("sequencer did not start on transfer");

endmodule

`default_nettype wire

// ----- tb/sliding_window_range_detector_top_tb.sv -----
// testbench for sliding_window_range_detector_top: predicts window range results per sample
// and checks every output transfer; needs swrd_pkg and the detector rtl only
module sliding_window_range_detector_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import swrd_pkg::*;

  localparam int SAMPLE_W    = DEF_SAMPLE_BITS;
  localparam int POS_W       = $clog2(DEF_MAX_STREAM_LEN) + 1;
  localparam int SAMPLE_MAX  = (1 << SAMPLE_W) - 1;
  localparam int MIN_SIDE    = 0;
  localparam int MAX_SIDE    = 1;
  localparam int LONG_STREAM = 1060;
  localparam int HOLD_CYCLES = 300;
  // drain wait sized for the worst sample: both deques emptied at the deepest window
  localparam int DRAIN_CYCLES = 15 + 2 * 2 * DEF_MAX_WINDOW + 104;
  // several times the longest quiet stretch: drain, receiver hold, worst sample
  localparam int STALL_LIMIT = 20000;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [POS_W-1:0] start_pos;
    logic             none_found;
  } window_result_t;

  // dut ports
  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [SAMPLE_W-1:0]   sample = '0;
  logic                  last_sample = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [POS_W-1:0]      start_pos;
  logic                  none_found;

  // predictor state: register copies, recent samples and the two position deques
  logic [WLEN_W-1:0]     win_len_reg = WLEN_RESET;
  logic [THR_W-1:0]      thr_reg = THR_RESET;
  logic [SAMPLE_W-1:0]   recent_samples [DEF_MAX_WINDOW];
  int unsigned           dq_pos [2][DEF_MAX_WINDOW];
  int unsigned           dq_head [2];
  int unsigned           dq_size [2];
  int unsigned           seen_count;
  int unsigned           stream_pos;
  bit                    window_found;
  window_result_t        expected_windows [$];

  // run controls and bookkeeping
  int  sender_gap_pct = 0;
  int  receiver_stall_pct = 0;
  bit  hold_req = 1'b0;
  int  idle_cycles = 0;
  int  mismatches = 0;
  int  samples_sent = 0;
  int  streams_closed = 0;
  int  results_checked = 0;
  int  none_checked = 0;
  int  cfg_writes = 0;

  sliding_window_range_detector_top i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .sample      (sample),
    .last_sample (last_sample),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .start_pos   (start_pos),
    .none_found  (none_found)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // zero reads as one, anything past the deepest window reads as the deepest
  function automatic int unsigned effective_window(input logic [WLEN_W-1:0] len);
    if (len == 0) return 1;
    if (len > DEF_MAX_WINDOW) return DEF_MAX_WINDOW;
    return len;
  endfunction

  // expire old positions at the front, drop dominated ones at the back, append
  function automatic void advance_deque(input int side, input int unsigned pos,
                                        input int unsigned win,
                                        input logic [SAMPLE_W-1:0] value);
    int unsigned         back_pos;
    logic [SAMPLE_W-1:0] back_val;
    bit                  drop;
    while (dq_size[side] > 0 && (pos - dq_pos[side][dq_head[side]]) >= win) begin
      dq_head[side] = (dq_head[side] + 1) % DEF_MAX_WINDOW;
      dq_size[side]--;
    end
    while (dq_size[side] > 0) begin
      back_pos = dq_pos[side][(dq_head[side] + dq_size[side] - 1) % DEF_MAX_WINDOW];
      back_val = recent_samples[back_pos % DEF_MAX_WINDOW];
      drop = (side == MAX_SIDE) ? (back_val <= value) : (back_val >= value);
      if (!drop) break;
      dq_size[side]--;
    end
    if (dq_size[side] >= DEF_MAX_WINDOW) begin
      dq_head[side] = (dq_head[side] + 1) % DEF_MAX_WINDOW;
      dq_size[side]--;
    end
    dq_pos[side][(dq_head[side] + dq_size[side]) % DEF_MAX_WINDOW] = pos;
    dq_size[side]++;
  endfunction

  // one accepted sample: slide the window, queue a start position or a none result
  function automatic void predict_window_check(input logic [SAMPLE_W-1:0] value,
                                               input logic closes);
    int unsigned         win;
    int unsigned         diff;
    logic [SAMPLE_W-1:0] lo;
    logic [SAMPLE_W-1:0] hi;
    window_result_t      res;
    bit                  hit;
    win = effective_window(win_len_reg);
    hit = 1'b0;
    stream_pos++;
    recent_samples[stream_pos % DEF_MAX_WINDOW] = value;
    advance_deque(MIN_SIDE, stream_pos, win, value);
    advance_deque(MAX_SIDE, stream_pos, win, value);
    if (seen_count < DEF_MAX_STREAM_LEN) seen_count++;
    if (seen_count >= win) begin
      lo = recent_samples[dq_pos[MIN_SIDE][dq_head[MIN_SIDE]] % DEF_MAX_WINDOW];
      hi = recent_samples[dq_pos[MAX_SIDE][dq_head[MAX_SIDE]] % DEF_MAX_WINDOW];
      diff = (hi >= lo) ? (hi - lo) : 0;
      if (diff <= thr_reg) begin
        res.start_pos = POS_W'(seen_count - win + 1);
        res.none_found = 1'b0;
        expected_windows.push_back(res);
        window_found = 1'b1;
        hit = 1'b1;
      end
    end
    if (closes) begin
      if (!hit && !window_found) begin
        res.start_pos = '0;
        res.none_found = 1'b1;
        expected_windows.push_back(res);
      end
      dq_head = '{0, 0};
      dq_size = '{0, 0};
      seen_count = 0;
      stream_pos = 0;
      window_found = 1'b0;
      streams_closed++;
    end
  endfunction

  function automatic void note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("%0t mismatch: %s", $time, msg);
  endfunction

  // output transfers against the oldest expectation
  always @(posedge clk) begin : result_check
    window_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_windows.size() == 0) begin
        note_mismatch($sformatf("result with nothing expected: start_pos %0d none_found %0b",
                                start_pos, none_found));
      end else begin
        want = expected_windows.pop_front();
        if (start_pos !== want.start_pos)
          note_mismatch($sformatf("start_pos expected %0d got %0d",
                                  want.start_pos, start_pos));
        if (none_found !== want.none_found)
          note_mismatch($sformatf("none_found expected %0b got %0b",
                                  want.none_found, none_found));
        results_checked++;
        if (want.none_found) none_checked++;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, expected_windows.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // receiver: random stall bursts, or one long counted hold on request
  initial begin : receiver
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (receiver_stall_pct > 0 && $urandom_range(0, 99) < receiver_stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 9)) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // called at a falling edge; returns at a falling edge with valid still high
  task automatic send_sample(input logic [SAMPLE_W-1:0] value, input logic closes);
    if (sender_gap_pct > 0 && $urandom_range(0, 99) < sender_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk);
    end
    in_valid    <= 1'b1;
    sample      <= value;
    last_sample <= closes;
    do @(posedge clk); while (in_stall);
    predict_window_check(value, closes);
    samples_sent++;
    @(negedge clk);
  endtask

  // quiet the input, let every result arrive, then cover samples with no result
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (expected_windows.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // register write, block idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (index == REG_WINDOW_LEN) win_len_reg = data[WLEN_W-1:0];
    else thr_reg = data[THR_W-1:0];
    cfg_writes++;
    @(negedge clk);
  endtask

  // window length with random bits above the register width
  function automatic logic [CFG_DATA_W-1:0] pick_window();
    logic [CFG_DATA_W-1:0] data;
    int                    roll;
    data = CFG_DATA_W'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 60) data[WLEN_W-1:0] = WLEN_W'($urandom_range(1, 8));
    else if (roll < 80) data[WLEN_W-1:0] = WLEN_W'($urandom_range(9, 32));
    else if (roll < 88) data[WLEN_W-1:0] = WLEN_W'($urandom_range(33, 64));
    else if (roll < 92) data[WLEN_W-1:0] = '0;
    else if (roll < 96) data[WLEN_W-1:0] = WLEN_W'(DEF_MAX_WINDOW);
    else data[WLEN_W-1:0] = WLEN_W'($urandom_range(DEF_MAX_WINDOW + 1, (1 << WLEN_W) - 1));
    return data;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_threshold();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 25) return '0;
    if (roll < 65) return CFG_DATA_W'($urandom_range(1, 32));
    if (roll < 85) return CFG_DATA_W'($urandom_range(33, 4095));
    if (roll < 95) return CFG_DATA_W'($urandom_range(4096, SAMPLE_MAX - 1));
    return CFG_DATA_W'(SAMPLE_MAX);
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 10;
      2: return 30;
      default: return 60;
    endcase
  endfunction

  // streams of samples in a band around the threshold, with some noise samples
  task automatic play_random_streams(input int n_items, input bit idling_on);
    int                  sent;
    int                  streams_left;
    int                  len;
    int                  spread;
    int                  change_at;
    int                  i;
    logic [SAMPLE_W-1:0] base;
    logic [SAMPLE_W-1:0] value;
    sent = 0;
    streams_left = 0;
    while (sent < n_items) begin
      if (streams_left == 0) begin
        wait_idle();
        write_reg(REG_WINDOW_LEN, pick_window());
        write_reg(REG_THRESHOLD, pick_threshold());
        streams_left = $urandom_range(2, 5);
        if (idling_on) begin
          sender_gap_pct = pick_pct();
          receiver_stall_pct = pick_pct();
        end
      end
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 8)
                                        : $urandom_range(1, 3 * effective_window(win_len_reg) + 4);
      if (len > 200) len = 200;
      if ($urandom_range(0, 9) < 6) spread = $urandom_range(0, thr_reg);
      else spread = $urandom_range(thr_reg, 2 * int'(thr_reg) + 4);
      if (spread > SAMPLE_MAX) spread = SAMPLE_MAX;
      base = SAMPLE_W'($urandom_range(0, SAMPLE_MAX - spread));
      change_at = ($urandom_range(0, 19) == 0) ? $urandom_range(2, len + 1) : 0;
      for (i = 1; i <= len; i++) begin
        // occasional window change in the middle of a stream
        if (i == change_at) begin
          wait_idle();
          write_reg(REG_WINDOW_LEN, CFG_DATA_W'($urandom_range(1, 16)));
        end
        if ($urandom_range(0, 9) == 0) value = SAMPLE_W'($urandom);
        else value = SAMPLE_W'(int'(base) + int'($urandom_range(0, spread)));
        send_sample(value, i == len);
        sent++;
      end
      streams_left--;
    end
  endtask

  // window length zero, bits above the register width, a lone closing sample
  task automatic test_window_floor();
    wait_idle();
    sender_gap_pct = 30;
    receiver_stall_pct = 30;
    write_reg(REG_WINDOW_LEN, 20'h00000);
    write_reg(REG_THRESHOLD, 20'h00000);
    send_sample(20'h00000, 1'b0);
    send_sample(20'hFFFFF, 1'b1);
    wait_idle();
    write_reg(REG_WINDOW_LEN, 20'hFF801);
    send_sample(20'h5A5A5, 1'b1);
  endtask

  // stream that closes before a full window
  task automatic test_short_stream();
    wait_idle();
    write_reg(REG_WINDOW_LEN, 20'd4);
    send_sample(20'd3, 1'b0);
    send_sample(20'd3, 1'b1);
  endtask

  // widest threshold with full-scale samples, then zero threshold with a hit before the end
  task automatic test_threshold_extremes();
    wait_idle();
    write_reg(REG_THRESHOLD, CFG_DATA_W'(SAMPLE_MAX));
    write_reg(REG_WINDOW_LEN, 20'd3);
    send_sample(20'h00000, 1'b0);
    send_sample(20'hFFFFF, 1'b0);
    send_sample(20'h00000, 1'b1);
    wait_idle();
    write_reg(REG_THRESHOLD, 20'd0);
    write_reg(REG_WINDOW_LEN, 20'd4);
    repeat (4) send_sample(20'd5, 1'b0);
    send_sample(20'd9, 1'b1);
  endtask

  // window grows in the middle of a stream
  task automatic test_window_change();
    wait_idle();
    write_reg(REG_WINDOW_LEN, 20'd2);
    write_reg(REG_THRESHOLD, 20'd1);
    send_sample(20'd10, 1'b0);
    send_sample(20'd11, 1'b0);
    wait_idle();
    write_reg(REG_WINDOW_LEN, 20'd4);
    send_sample(20'd11, 1'b0);
    send_sample(20'd11, 1'b1);
  endtask

  // oversized window length clamps to the deepest window; ramp with noise and one spike
  task automatic test_long_window();
    logic [CFG_DATA_W-1:0] data;
    logic [SAMPLE_W-1:0]   base;
    logic [SAMPLE_W-1:0]   value;
    int                    thr;
    int                    i;
    wait_idle();
    sender_gap_pct = 10;
    receiver_stall_pct = 10;
    data = CFG_DATA_W'($urandom);
    data[WLEN_W-1:0] = '1;
    write_reg(REG_WINDOW_LEN, data);
    thr = $urandom_range(16, 4000);
    write_reg(REG_THRESHOLD, CFG_DATA_W'(thr));
    base = SAMPLE_W'($urandom_range(0, SAMPLE_MAX - thr - 16));
    for (i = 1; i <= LONG_STREAM; i++) begin
      if (i == LONG_STREAM - 20)
        value = SAMPLE_W'(int'(base) + thr + int'($urandom_range(1, 15)));
      else
        value = SAMPLE_W'(int'(base) + (i * thr) / (2 * LONG_STREAM)
                          + int'($urandom_range(0, thr / 2)));
      send_sample(value, i == LONG_STREAM);
    end
  endtask

  // long receiver hold fills the block; then the sender waits for every result
  task automatic test_backpressure();
    int i;
    wait_idle();
    sender_gap_pct = 0;
    receiver_stall_pct = 0;
    write_reg(REG_WINDOW_LEN, 20'd1);
    write_reg(REG_THRESHOLD, CFG_DATA_W'(SAMPLE_MAX));
    @(posedge clk);
    hold_req = 1'b1;
    @(negedge clk);
    for (i = 0; i < 40; i++) send_sample(SAMPLE_W'($urandom), 1'b0);
    in_valid <= 1'b0;
    do @(negedge clk); while (expected_windows.size() != 0);
    sender_gap_pct = 20;
    for (i = 1; i <= 20; i++) send_sample(SAMPLE_W'($urandom), i == 20);
  endtask

  task automatic test_random_streams(input int n_items);
    play_random_streams(n_items, 1'b1);
  endtask

  // closing stretch at full rate on both sides
  task automatic test_full_rate_tail(input int n_items);
    sender_gap_pct = 0;
    receiver_stall_pct = 0;
    play_random_streams(n_items, 1'b0);
  endtask

  initial begin
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    test_window_floor();
    test_short_stream();
    test_threshold_extremes();
    test_window_change();
    test_long_window();
    test_backpressure();
    test_random_streams(700);
    test_full_rate_tail(150);
    wait_idle();
    $display("sent %0d samples in %0d streams with %0d register writes, window 0 to 2047",
             samples_sent, streams_closed, cfg_writes);
    $display("checked %0d results (%0d none-found), %0d mismatches",
             results_checked, none_checked, mismatches);
    if (mismatches == 0 && expected_windows.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
